@@ sv/taeb_pkg.sv @@
// ----------------------------------------------------------------------------
// Event builder package
// Shared types and constants for the trigger aligned event builder.
// ----------------------------------------------------------------------------
package taeb_pkg;
  localparam int NUM_SOURCES = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int SRC_W = 3;
  localparam int SEL_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = SEL_W + SLOT_W;
  localparam int MEM_DEPTH = NUM_SOURCES * QUEUE_DEPTH;
  localparam int FIFO_DEPTH = 2;

  localparam logic [1:0] CMD_RECEIVE = 2'd0;
  localparam logic [1:0] CMD_CONNECT = 2'd1;
  localparam logic [1:0] CMD_DISCONNECT = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [SRC_W-1:0] src;
    logic [31:0] trig;
    logic [15:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [31:0] trig;
    logic [SRC_W-1:0] src;
    logic [15:0] handle;
    logic        last;
  } res_t;
endpackage

@@ sv/taeb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module taeb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/taeb_front.sv @@
// ----------------------------------------------------------------------------
// Command front end
// Accepts words, drops those naming a source out of range and queues the rest.
// ----------------------------------------------------------------------------
module taeb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  taeb_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output taeb_pkg::cmd_t q_cmd
);
  import taeb_pkg::*;

  cmd_t buf_r [FIFO_DEPTH];
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop, keep;

  assign keep = (in_cmd.cmd == CMD_CLEAR) || (32'(in_cmd.src) < NUM_SOURCES);
  assign in_ready = (cnt_r != 2'(FIFO_DEPTH));
  assign push = in_valid && in_ready && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = buf_r[rd_r];

  always_comb begin
    rd_nxt = rd_r ^ pop;
    wr_nxt = wr_r ^ push;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      buf_r[wr_r] <= in_cmd;
    end
  end
endmodule

@@ sv/taeb_back.sv @@
// ----------------------------------------------------------------------------
// Build engine
// Keeps the source queues, finds the oldest trigger and emits its fragments.
// ----------------------------------------------------------------------------
module taeb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  taeb_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output taeb_pkg::res_t out_res
);
  import taeb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [NUM_SOURCES-1:0] pres_r, pres_nxt, inact_r, inact_nxt;
  logic [SLOT_W-1:0] head_r [NUM_SOURCES];
  logic [CNT_W-1:0]  cnt_r [NUM_SOURCES];
  logic [31:0] front_r [NUM_SOURCES];
  logic [15:0] fhand_r [NUM_SOURCES];
  logic [31:0] min_r, min_nxt;
  logic [NUM_SOURCES-1:0] hit_r, hit_nxt;
  logic ov_r, ov_nxt;
  res_t ores_r, ores_nxt;
  logic [NUM_SOURCES-1:0] dirty_r;
  logic [SEL_W-1:0] rf_r;
  logic rfv_r;

  logic we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0] rtrig;
  logic [15:0] rhand;
  logic [SEL_W-1:0] qs;
  logic [SLOT_W-1:0] wslot;
  logic allnz;
  logic [31:0] tmin [NUM_SOURCES];
  logic [SEL_W-1:0] pick, rsel;
  logic [NUM_SOURCES-1:0] dirty_rest;

  assign qs = q_cmd.src[SEL_W-1:0];
  assign q_ready = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_res = ores_r;
  assign wslot = SLOT_W'((32'(head_r[qs]) + 32'(cnt_r[qs])) % QUEUE_DEPTH);
  assign we = q_valid && q_ready && (q_cmd.cmd == CMD_RECEIVE) &&
              (32'(cnt_r[qs]) < QUEUE_DEPTH);
  assign waddr = {qs, wslot};
  assign raddr = {rsel, head_r[rsel]};

  taeb_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_trig (
    .clk(clk), .we(we), .waddr(waddr), .wdata(q_cmd.trig),
    .raddr(raddr), .rdata(rtrig));
  taeb_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_hand (
    .clk(clk), .we(we), .waddr(waddr), .wdata(q_cmd.handle),
    .raddr(raddr), .rdata(rhand));

  // The smallest front is found by a pairwise tree; absent sources count as
  // the largest trigger number.
  always_comb begin
    allnz = 1'b1;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (pres_r[i] && cnt_r[i] == '0) allnz = 1'b0;
      tmin[i] = pres_r[i] ? front_r[i] : '1;
    end
    for (int w = 1; w < NUM_SOURCES; w = w * 2) begin
      for (int i = 0; i + w < NUM_SOURCES; i = i + 2 * w) begin
        if (tmin[i + w] < tmin[i]) tmin[i] = tmin[i + w];
      end
    end
    pick = '0;
    rsel = '0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (hit_r[i]) pick = SEL_W'(i);
      if (dirty_r[i]) rsel = SEL_W'(i);
    end
    dirty_rest = dirty_r;
    dirty_rest[rsel] = 1'b0;
  end

  always_comb begin
    st_nxt = st_r;
    pres_nxt = pres_r;
    inact_nxt = inact_r;
    min_nxt = min_r;
    hit_nxt = hit_r;
    ov_nxt = ov_r;
    ores_nxt = ores_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.cmd)
            CMD_RECEIVE: begin
              pres_nxt[qs] = 1'b1;
              st_nxt = ST_SCAN;
            end
            CMD_CONNECT: begin
              pres_nxt[qs] = 1'b1;
              inact_nxt[qs] = 1'b0;
            end
            CMD_DISCONNECT: begin
              inact_nxt[qs] = 1'b1;
              if ((pres_r & ~inact_nxt) == '0) begin
                pres_nxt = '0;
                inact_nxt = '0;
              end
            end
            default: begin
              pres_nxt = '0;
              inact_nxt = '0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        min_nxt = '1;
        hit_nxt = '0;
        if (allnz) begin
          min_nxt = tmin[0];
          for (int i = 0; i < NUM_SOURCES; i++) begin
            hit_nxt[i] = pres_r[i] && (front_r[i] == tmin[0]);
          end
          st_nxt = ST_EMIT;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (hit_r == '0) begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (inact_r[i] && pres_r[i] && cnt_r[i] == '0) begin
              pres_nxt[i] = 1'b0;
              inact_nxt[i] = 1'b0;
            end
          end
          st_nxt = ST_READ;
        end else if (!ov_r || out_ready) begin
          hit_nxt[pick] = 1'b0;
          ov_nxt = 1'b1;
          ores_nxt.trig = min_r;
          ores_nxt.src = SRC_W'(pick);
          ores_nxt.handle = fhand_r[pick];
          ores_nxt.last = (hit_nxt == '0);
        end
      end
      ST_READ: begin
        if (dirty_rest == '0) st_nxt = ST_OUT;
      end
      ST_OUT: begin
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Front copies are refreshed for the popped sources through the RAM read
  // port: one source a cycle during the refill pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      pres_r <= '0;
      inact_r <= '0;
      ov_r <= 1'b0;
      dirty_r <= '0;
      rfv_r <= 1'b0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        head_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      pres_r <= pres_nxt;
      inact_r <= inact_nxt;
      ov_r <= ov_nxt;
      rfv_r <= 1'b0;
      if (st_r == ST_IDLE && q_valid) begin
        case (q_cmd.cmd)
          CMD_RECEIVE: begin
            if (we) begin
              cnt_r[qs] <= cnt_r[qs] + CNT_W'(1);
              if (cnt_r[qs] == '0) begin
                front_r[qs] <= q_cmd.trig;
                fhand_r[qs] <= q_cmd.handle;
              end
            end
          end
          CMD_CONNECT: begin
            head_r[qs] <= '0;
            cnt_r[qs] <= '0;
          end
          CMD_DISCONNECT: begin
            if (pres_nxt == '0) begin
              for (int i = 0; i < NUM_SOURCES; i++) begin
                head_r[i] <= '0;
                cnt_r[i] <= '0;
              end
            end
          end
          default: begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
              head_r[i] <= '0;
              cnt_r[i] <= '0;
            end
          end
        endcase
      end
      if (st_r == ST_EMIT && hit_r != '0 && (!ov_r || out_ready)) begin
        head_r[pick] <= SLOT_W'((32'(head_r[pick]) + 1) % QUEUE_DEPTH);
        cnt_r[pick] <= cnt_r[pick] - CNT_W'(1);
        dirty_r[pick] <= 1'b1;
      end
      if (st_r == ST_READ && dirty_r != '0) begin
        rfv_r <= 1'b1;
        rf_r <= rsel;
        dirty_r[rsel] <= 1'b0;
      end
      if (rfv_r) begin
        front_r[rf_r] <= rtrig;
        fhand_r[rf_r] <= rhand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '1;
      hit_r <= '0;
    end else begin
      min_r <= min_nxt;
      hit_r <= hit_nxt;
    end
    ores_r <= ores_nxt;
  end
endmodule

@@ sv/trigger_aligned_event_builder.sv @@
// ----------------------------------------------------------------------------
// Trigger aligned event builder
// Per source fragment queues; emits all fronts with the smallest trigger.
// ----------------------------------------------------------------------------
// A receive that completes an event passes the command queue, the scan state
// and the emit state, whose output word is registered. Each fragment gives one
// output word and one front refill; words follow while out is not stalled.
// The engine takes commands only in idle; connect, disconnect and clear end
// there, a receive passes scan and, if it builds an event, emit, refill, out.
// Reset: synchronous; all queues empty and no source present.
module trigger_aligned_event_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  input  logic [55:0] in_tdata,   // source_index, trigger_number, payload_handle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // built_trigger, from_source, fragment_handle
  output logic        out_tlast
);
  import taeb_pkg::*;

  cmd_t icmd, qcmd;
  res_t res;
  logic qv, qr;

  assign icmd.cmd = in_tuser;
  assign icmd.src = in_tdata[2:0];
  assign icmd.trig = in_tdata[34:3];
  assign icmd.handle = in_tdata[50:35];

  taeb_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(icmd), .q_valid(qv), .q_ready(qr), .q_cmd(qcmd));

  taeb_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(qv), .q_ready(qr), .q_cmd(qcmd),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res));

  assign out_tdata = {5'd0, res.handle, res.src, res.trig};
  assign out_tlast = res.last;
endmodule

@@ sv/taeb_checker.sv @@
// ----------------------------------------------------------------------------
// Event builder checker
// Port level properties of the event builder.
// ----------------------------------------------------------------------------
module taeb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled word changed");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:51] == 5'd0)
    else $error("padding not zero");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_trig: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid |->
    out_tdata[31:0] == $past(out_tdata[31:0]))
    else $error("trigger changed within event");
endmodule

bind trigger_aligned_event_builder taeb_checker u_checker (.*);
